// ===== rtl/bls_pkg.sv =====
// Shared types and constants for the line stepper.
// Used by every module in rtl/; depends on nothing.
package bls_pkg;

    localparam int COORD_BITS = 12;
    localparam int ROW_W      = 13;
    localparam int RGB_W      = 24;
    localparam int OFF_W      = 24;

    // Error accumulator: stored value and the wider pre-correction sum
    localparam int ACC_W      = COORD_BITS + 2;
    localparam int ERR_W      = COORD_BITS + 3;
    localparam int INC_W      = COORD_BITS + 1;

    // Offset product plus the x add, wide enough to truncate to OFF_W
    localparam int PROD_W     = COORD_BITS + ROW_W + 1;
    localparam int SUM_W      = (PROD_W > OFF_W) ? PROD_W : OFF_W;

    localparam logic [ROW_W-1:0] ROW_WIDTH_RST = ROW_W'(640);

    typedef enum logic
    {
        REQ_START   = 1'b0,
        REQ_ADVANCE = 1'b1
    } req_t;

    // Classified command, front to back
    typedef struct packed
    {
        req_t                  req;
        logic                  steep;
        logic [COORD_BITS-1:0] major_lo;
        logic [COORD_BITS-1:0] major_hi;
        logic [COORD_BITS-1:0] minor_lo;
        logic                  step_down;
        logic [COORD_BITS-1:0] span;
        logic [INC_W-1:0]      inc;
        logic [RGB_W-1:0]      rgb;
    } cmd_t;

    // Pixel record, back to offset stage
    typedef struct packed
    {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [RGB_W-1:0]      rgb;
        logic                  last;
    } pix_t;

endpackage

// ===== rtl/bls_front.sv =====
// Front end: classifies a request and works out the line setup for a start.
// Depends on bls_pkg (cmd_t, req_t, widths).
module bls_front
(
    input  logic                           req_type,
    input  logic [bls_pkg::COORD_BITS-1:0] x_start,
    input  logic [bls_pkg::COORD_BITS-1:0] y_start,
    input  logic [bls_pkg::COORD_BITS-1:0] x_end,
    input  logic [bls_pkg::COORD_BITS-1:0] y_end,
    input  logic [bls_pkg::RGB_W-1:0]      line_rgb,
    output bls_pkg::cmd_t                  cmd
);

    logic [bls_pkg::COORD_BITS-1:0] adx;
    logic [bls_pkg::COORD_BITS-1:0] ady;
    logic                           x_desc;
    logic                           y_desc;
    logic                           steep;
    logic                           swap;

    always_comb
    begin
        x_desc = x_start > x_end;
        y_desc = y_start > y_end;
        adx    = x_desc ? (x_start - x_end) : (x_end - x_start);
        ady    = y_desc ? (y_start - y_end) : (y_end - y_start);
        steep  = adx < ady;
        // order endpoints so the major coordinate increases
        swap   = steep ? y_desc : x_desc;

        cmd.req      = bls_pkg::req_t'(req_type);
        cmd.steep    = steep;
        cmd.rgb      = line_rgb;
        cmd.span     = steep ? ady : adx;
        cmd.inc      = {(steep ? adx : ady), 1'b0};
        if (steep)
        begin
            cmd.major_lo  = swap ? y_end : y_start;
            cmd.major_hi  = swap ? y_start : y_end;
            cmd.minor_lo  = swap ? x_end : x_start;
            cmd.step_down = swap ? !(x_start > x_end) : !(x_end > x_start);
        end
        else
        begin
            cmd.major_lo  = swap ? x_end : x_start;
            cmd.major_hi  = swap ? x_start : x_end;
            cmd.minor_lo  = swap ? y_end : y_start;
            cmd.step_down = swap ? !y_desc : !(y_end > y_start);
        end
    end

endmodule

// ===== rtl/bls_queue.sv =====
// Two-entry command queue between the front end and the stepper.
// Depends on bls_pkg (cmd_t).
module bls_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bls_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          not_empty,
    input  logic          pop,
    output bls_pkg::cmd_t head_cmd
);

    bls_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    always_comb
    begin
        full        = count_reg == 2'd2;
        not_empty   = count_reg != 2'd0;
        head_cmd    = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/bls_back.sv =====
// Stepper: holds the line state, runs the error update and registers one pixel.
// Depends on bls_pkg (cmd_t, pix_t, req_t, widths).
module bls_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  bls_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          pix_valid,
    output bls_pkg::pix_t pix,
    input  logic          pix_ready
);

    logic                           active_reg, active_next;
    logic                           steep_reg, steep_next;
    logic [bls_pkg::COORD_BITS-1:0] major_reg, major_next;
    logic [bls_pkg::COORD_BITS-1:0] stop_reg, stop_next;
    logic [bls_pkg::COORD_BITS-1:0] minor_reg, minor_next;
    logic                           down_reg, down_next;
    logic [bls_pkg::COORD_BITS-1:0] span_reg, span_next;
    logic [bls_pkg::INC_W-1:0]      inc_reg, inc_next;
    logic [bls_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [bls_pkg::RGB_W-1:0]      rgb_reg, rgb_next;
    logic                           pix_valid_reg, pix_valid_next;
    bls_pkg::pix_t                  pix_reg, pix_next;

    logic                           stage_free;
    logic                           emit;
    logic [bls_pkg::ERR_W-1:0]      err_sum;
    logic [bls_pkg::ERR_W-1:0]      err_fix;
    logic                           minor_step;
    logic                           last;

    always_comb
    begin
        stage_free = !pix_valid_reg || pix_ready;
        cmd_pop    = cmd_valid && stage_free;

        active_next = active_reg;
        steep_next  = steep_reg;
        major_next  = major_reg;
        stop_next   = stop_reg;
        minor_next  = minor_reg;
        down_next   = down_reg;
        span_next   = span_reg;
        inc_next    = inc_reg;
        acc_next    = acc_reg;
        rgb_next    = rgb_reg;
        emit        = 1'b0;

        err_sum    = {acc_reg[bls_pkg::ACC_W-1], acc_reg} + {2'b00, inc_reg};
        minor_step = $signed(err_sum) > $signed({3'b000, span_reg});
        err_fix    = err_sum - {2'b00, span_reg, 1'b0};

        if (cmd_pop)
        begin
            unique case (cmd.req)
                bls_pkg::REQ_START:
                begin
                    steep_next  = cmd.steep;
                    major_next  = cmd.major_lo;
                    stop_next   = cmd.major_hi;
                    minor_next  = cmd.minor_lo;
                    down_next   = cmd.step_down;
                    span_next   = cmd.span;
                    inc_next    = cmd.inc;
                    acc_next    = '0;
                    rgb_next    = cmd.rgb;
                    active_next = 1'b1;
                    emit        = 1'b1;
                end
                bls_pkg::REQ_ADVANCE:
                begin
                    // drop an advance that arrives with no line in progress
                    if (active_reg)
                    begin
                        major_next = major_reg + 1'b1;
                        if (minor_step)
                        begin
                            minor_next = down_reg ? (minor_reg - 1'b1) : (minor_reg + 1'b1);
                            acc_next   = err_fix[bls_pkg::ACC_W-1:0];
                        end
                        else
                        begin
                            acc_next = err_sum[bls_pkg::ACC_W-1:0];
                        end
                        emit = 1'b1;
                    end
                end
            endcase
        end

        last = major_next == stop_next;
        if (emit && last)
        begin
            active_next = 1'b0;
        end

        pix_next.x    = steep_next ? minor_next : major_next;
        pix_next.y    = steep_next ? major_next : minor_next;
        pix_next.rgb  = rgb_next;
        pix_next.last = last;

        pix_valid_next = stage_free ? emit : pix_valid_reg;

        pix_valid = pix_valid_reg;
        pix       = pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steep_reg <= steep_next;
        major_reg <= major_next;
        stop_reg  <= stop_next;
        minor_reg <= minor_next;
        down_reg  <= down_next;
        span_reg  <= span_next;
        inc_reg   <= inc_next;
        acc_reg   <= acc_next;
        rgb_reg   <= rgb_next;
        if (stage_free && emit)
        begin
            pix_reg <= pix_next;
        end
    end

endmodule

// ===== rtl/bls_addr.sv =====
// Offset stage: holds row_width, forms y*row_width+x and drives the output register.
// Depends on bls_pkg (pix_t, widths).
module bls_addr
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bls_pkg::ROW_W-1:0]      cfg_wr_data,
    input  logic                           pix_valid,
    input  bls_pkg::pix_t                  pix,
    output logic                           pix_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bls_pkg::COORD_BITS-1:0] pixel_x,
    output logic [bls_pkg::COORD_BITS-1:0] pixel_y,
    output logic [bls_pkg::OFF_W-1:0]      pixel_offset,
    output logic [bls_pkg::RGB_W-1:0]      pixel_rgb,
    output logic                           last_pixel
);

    logic [bls_pkg::ROW_W-1:0]      row_width_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [bls_pkg::COORD_BITS-1:0] x_reg;
    logic [bls_pkg::COORD_BITS-1:0] y_reg;
    logic [bls_pkg::OFF_W-1:0]      off_reg, off_next;
    logic [bls_pkg::RGB_W-1:0]      rgb_reg;
    logic                           last_reg;
    logic [bls_pkg::SUM_W-1:0]      sum;
    logic                           load;

    always_comb
    begin
        pix_ready      = !out_valid_reg || out_ready;
        load           = pix_valid && pix_ready;
        out_valid_next = pix_ready ? pix_valid : out_valid_reg;
        sum            = bls_pkg::SUM_W'(pix.y) * bls_pkg::SUM_W'(row_width_reg)
                       + bls_pkg::SUM_W'(pix.x);
        off_next       = sum[bls_pkg::OFF_W-1:0];

        out_valid    = out_valid_reg;
        pixel_x      = x_reg;
        pixel_y      = y_reg;
        pixel_offset = off_reg;
        pixel_rgb    = rgb_reg;
        last_pixel   = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= bls_pkg::ROW_WIDTH_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                row_width_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= pix.x;
            y_reg    <= pix.y;
            off_reg  <= off_next;
            rgb_reg  <= pix.rgb;
            last_reg <= pix.last;
        end
    end

endmodule

// ===== rtl/bresenham_line_stepper.sv =====
// Top level of the line stepper: front end, command queue, stepper, offset stage.
// Depends on bls_pkg, bls_front, bls_queue, bls_back, bls_addr.
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------------------
//   request   in_valid / in_ready    req_type, x_start, y_start, x_end, y_end, line_rgb
//   pixel     out_valid / out_ready  pixel_x, pixel_y, pixel_offset, pixel_rgb, last_pixel
//   config    cfg_wr_en              cfg_wr_data (row_width)
//
// One request per clock and one pixel per clock while the output is taken every cycle.
// A request reaches the output through the queue write at the transfer edge, then the stepper
// register, then the offset register (multiply y by row_width and add x).
// Reset clears all valids and the active line; row_width returns to 640.
// A stalled output fills the stages and then the two-entry queue before in_ready drops.
module bresenham_line_stepper
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bls_pkg::ROW_W-1:0]      cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [bls_pkg::COORD_BITS-1:0] x_start,
    input  logic [bls_pkg::COORD_BITS-1:0] y_start,
    input  logic [bls_pkg::COORD_BITS-1:0] x_end,
    input  logic [bls_pkg::COORD_BITS-1:0] y_end,
    input  logic [bls_pkg::RGB_W-1:0]      line_rgb,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bls_pkg::COORD_BITS-1:0] pixel_x,
    output logic [bls_pkg::COORD_BITS-1:0] pixel_y,
    output logic [bls_pkg::OFF_W-1:0]      pixel_offset,
    output logic [bls_pkg::RGB_W-1:0]      pixel_rgb,
    output logic                           last_pixel
);

    bls_pkg::cmd_t front_cmd;
    bls_pkg::cmd_t head_cmd;
    logic          q_full;
    logic          q_not_empty;
    logic          q_pop;
    logic          push;
    logic          pix_valid;
    logic          pix_ready;
    bls_pkg::pix_t pix;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    bls_front u_front
    (
        .req_type (req_type),
        .x_start  (x_start),
        .y_start  (y_start),
        .x_end    (x_end),
        .y_end    (y_end),
        .line_rgb (line_rgb),
        .cmd      (front_cmd)
    );

    bls_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .head_cmd  (head_cmd)
    );

    bls_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .pix_valid (pix_valid),
        .pix       (pix),
        .pix_ready (pix_ready)
    );

    bls_addr u_addr
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .pix_valid    (pix_valid),
        .pix          (pix),
        .pix_ready    (pix_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_offset (pixel_offset),
        .pixel_rgb    (pixel_rgb),
        .last_pixel   (last_pixel)
    );

endmodule
